@@ hw/rtl/vig_pkg.sv @@
// ----------------------------------------------------------------------------
// vig_pkg: shared definitions for the 32-symbol Vigenere encryptor
// Alphabet table, byte classification, key shift lookup and the types that
// pass between the front end, the symbol queue and the output stage.
// ----------------------------------------------------------------------------
package vig_pkg;

  localparam int SYM_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int KEY_REGS    = 6;
  localparam int BYTES_PER_REG = 8;
  localparam int MAX_KEY_LEN = KEY_REGS * BYTES_PER_REG;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [SYM_W-1:0]      sym_t;
  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CFG_DATA_W-1:0] key_reg_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_LAST = 3'd6;

  // Latin-1 codes used for classification.
  localparam byte_t LOWER_A      = 8'd97;
  localparam byte_t LOWER_Z      = 8'd122;
  localparam byte_t UPPER_A      = 8'd65;
  localparam byte_t UPPER_Z      = 8'd90;
  localparam byte_t LOWER_ARING  = 8'd229;
  localparam byte_t UPPER_ARING  = 8'd197;
  localparam byte_t LOWER_AUML   = 8'd228;
  localparam byte_t UPPER_AUML   = 8'd196;
  localparam byte_t LOWER_OUML   = 8'd246;
  localparam byte_t UPPER_OUML   = 8'd214;
  localparam byte_t CHAR_SPACE   = 8'd32;
  localparam byte_t CHAR_COMMA   = 8'd44;
  localparam byte_t CHAR_PERIOD  = 8'd46;

  localparam sym_t SYM_ARING  = 5'd26;
  localparam sym_t SYM_AUML   = 5'd27;
  localparam sym_t SYM_OUML   = 5'd28;
  localparam sym_t SYM_SPACE  = 5'd29;
  localparam sym_t SYM_COMMA  = 5'd30;
  localparam sym_t SYM_PERIOD = 5'd31;

  localparam byte_t ALPHABET [32] = '{
    8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
    8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
    8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
    8'd121, 8'd122, 8'd229, 8'd228, 8'd246, 8'd32,  8'd44,  8'd46
  };

  typedef struct packed {
    logic en;
    logic [CFG_IDX_W-1:0] index;
    key_reg_t data;
  } cfg_wr_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef struct packed {
    logic ok;
    sym_t sym;
  } class_t;

  // Maps a plaintext byte to its alphabet position, folding upper case.
  function automatic class_t plain_index(byte_t b);
    class_t c;
    c.ok  = 1'b1;
    c.sym = '0;
    if (b >= LOWER_A && b <= LOWER_Z) begin
      c.sym = SYM_W'(b - LOWER_A);
    end else if (b >= UPPER_A && b <= UPPER_Z) begin
      c.sym = SYM_W'(b - UPPER_A);
    end else if (b == LOWER_ARING || b == UPPER_ARING) begin
      c.sym = SYM_ARING;
    end else if (b == LOWER_AUML || b == UPPER_AUML) begin
      c.sym = SYM_AUML;
    end else if (b == LOWER_OUML || b == UPPER_OUML) begin
      c.sym = SYM_OUML;
    end else if (b == CHAR_SPACE) begin
      c.sym = SYM_SPACE;
    end else if (b == CHAR_COMMA) begin
      c.sym = SYM_COMMA;
    end else if (b == CHAR_PERIOD) begin
      c.sym = SYM_PERIOD;
    end else begin
      c.ok = 1'b0;
    end
    return c;
  endfunction

  // Key bytes are not case folded; a byte outside the alphabet shifts by zero.
  function automatic sym_t key_shift(byte_t k);
    sym_t s;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      if (ALPHABET[i] == k) begin
        s = SYM_W'(i);
      end
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/vig_front.sv @@
// ----------------------------------------------------------------------------
// vig_front: input classification and key application
// Holds the key registers and the key position, drops bytes outside the
// alphabet and pushes the shifted symbol into the queue.
// ----------------------------------------------------------------------------
module vig_front (
  input  logic               clk,
  input  logic               rst,
  input  vig_pkg::cfg_wr_t   cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  vig_pkg::byte_t     plain_byte,
  input  vig_pkg::q_status_t q_status,
  output logic               push,
  output vig_pkg::sym_t      push_sym
);

  logic [vig_pkg::POS_W-1:0] key_length;
  vig_pkg::key_reg_t         key_regs [vig_pkg::KEY_REGS];
  vig_pkg::pos_t             key_position;
  vig_pkg::pos_t             key_position_next;

  vig_pkg::pos_t    eff_len;
  vig_pkg::pos_t    pos_used;
  vig_pkg::pos_t    pos_inc;
  vig_pkg::byte_t   key_byte;
  vig_pkg::class_t  cls;
  vig_pkg::key_reg_t key_word;

  assign in_ready = !q_status.full;
  assign cls      = vig_pkg::plain_index(plain_byte);
  assign push     = in_valid && in_ready && cls.ok;

  always_comb begin
    if (key_length == '0) begin
      eff_len = vig_pkg::POS_W'(1);
    end else if (key_length > vig_pkg::POS_W'(vig_pkg::MAX_KEY_LEN)) begin
      eff_len = vig_pkg::POS_W'(vig_pkg::MAX_KEY_LEN);
    end else begin
      eff_len = key_length;
    end
  end

  // A position left beyond a shortened key starts over at the first character.
  assign pos_used = (key_position >= eff_len) ? '0 : key_position;
  assign pos_inc  = pos_used + vig_pkg::POS_W'(1);
  assign key_position_next = (pos_inc >= eff_len) ? '0 : pos_inc;

  assign key_word = key_regs[pos_used[vig_pkg::POS_W-1:3]];
  assign key_byte = key_word[{pos_used[2:0], 3'b000} +: vig_pkg::BYTE_W];
  assign push_sym = cls.sym + vig_pkg::key_shift(key_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= vig_pkg::POS_W'(1);
      key_position <= '0;
      for (int r = 0; r < vig_pkg::KEY_REGS; r++) begin
        key_regs[r] <= '0;
      end
    end else begin
      if (cfg.en) begin
        if (cfg.index == vig_pkg::CFG_KEY_LENGTH) begin
          key_length <= cfg.data[vig_pkg::POS_W-1:0];
        end else if (cfg.index >= vig_pkg::CFG_KEY_BYTES_0 &&
                     cfg.index <= vig_pkg::CFG_KEY_BYTES_LAST) begin
          key_regs[cfg.index - vig_pkg::CFG_KEY_BYTES_0] <= cfg.data;
        end
      end
      if (push) begin
        key_position <= key_position_next;
      end
    end
  end

endmodule

@@ hw/rtl/vig_queue.sv @@
// ----------------------------------------------------------------------------
// vig_queue: symbol queue between front end and output stage
// Small FIFO that allows a push and a pop in the same cycle.
// ----------------------------------------------------------------------------
module vig_queue #(
  parameter int Depth = vig_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vig_pkg::sym_t      push_sym,
  input  logic               pop,
  output vig_pkg::sym_t      pop_sym,
  output vig_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(Depth);
  localparam int CNT_W = $clog2(Depth + 1);

  vig_pkg::sym_t    slots [Depth];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign pop_sym          = slots[rd_ptr];
  assign status.full      = (count == CNT_W'(Depth));
  assign status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Depth))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == CNT_W'($past(count) + 1'b1))
    else $error("push not reflected in count");

endmodule

@@ hw/rtl/vig_back.sv @@
// ----------------------------------------------------------------------------
// vig_back: output stage
// Pops symbols from the queue and registers the matching alphabet byte.
// ----------------------------------------------------------------------------
module vig_back (
  input  logic               clk,
  input  logic               rst,
  input  vig_pkg::q_status_t q_status,
  input  vig_pkg::sym_t      pop_sym,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output vig_pkg::byte_t     cipher_byte
);

  assign pop = q_status.not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cipher_byte <= vig_pkg::ALPHABET[pop_sym];
    end
  end

endmodule

@@ hw/rtl/vigenere_encrypt_32_symbol.sv @@
// ----------------------------------------------------------------------------
// vigenere_encrypt_32_symbol: Vigenere encryptor over a 32-symbol alphabet
// Encrypts a stream of Latin-1 bytes with a key of up to 48 characters.
// ----------------------------------------------------------------------------
// The block takes one plaintext byte per cycle while the queue is not full and
// returns one ciphertext beat per byte through the queue and an output register.
// Bytes outside the alphabet are consumed and produce no beat. The front end
// classifies the byte and adds the key shift in the cycle of acceptance and
// writes the symbol into a two-entry queue; the output stage turns it into
// its alphabet byte in a register. A full queue holds off input, so the
// sustained rate is one byte per cycle for as long as the output is taken.
// Write key_length and key_bytes_0..5 only while no byte is in flight.
module vigenere_encrypt_32_symbol #(
  parameter int QueueDepth = vig_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [vig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vig_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        plain_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        cipher_byte
);

  vig_pkg::cfg_wr_t   cfg;
  vig_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  vig_pkg::sym_t      push_sym;
  vig_pkg::sym_t      pop_sym;

  assign cfg.en    = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  vig_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .plain_byte (plain_byte),
    .q_status   (q_status),
    .push       (push),
    .push_sym   (push_sym)
  );

  vig_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_sym (push_sym),
    .pop      (pop),
    .pop_sym  (pop_sym),
    .status   (q_status)
  );

  vig_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop_sym     (pop_sym),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cipher_byte (cipher_byte)
  );

endmodule
